// ===== rtl/imugc_pkg.sv =====
// ----------------------------------------------------------------------------
// imugc_pkg
// Shared types, register indexes, gesture codes and reset constants for the
// IMU gesture classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package imugc_pkg;

    // default sample rate of the yaw integrator
    localparam int SAMPLE_RATE_HZ_DEF = 100;

    // fixed field widths
    localparam int TIME_W  = 32;
    localparam int AXIS_W  = 16;
    localparam int CFG_W   = 16;
    localparam int LEVEL_W = 15;
    localparam int IDX_W   = 3;
    localparam int SQ_W    = 31;  // one squared axis, or a squared threshold
    localparam int SUMSQ_W = 32;  // sum of three squared axes

    // Q8.8 constants
    localparam int GRAVITY_Q8      = 2511;
    localparam int SHAKE_RATE_X_Q8 = 1536;
    localparam int STAB_AY_Q8      = -2048;
    localparam int STAB_NET_Q8     = 1792;

    // register reset values
    localparam logic [CFG_W-1:0]   HOLD_TIME_RST   = 16'd800;
    localparam logic [CFG_W-1:0]   COOLDOWN_RST    = 16'd300;
    localparam int                 HARD_FLICK_RST  = 6400;
    localparam int                 FLICK_RST       = 3840;
    localparam int                 SHAKE_RST       = 2048;
    localparam logic [LEVEL_W-1:0] SWIPE_RATE_RST  = 15'd1024;
    localparam logic [LEVEL_W-1:0] CIRCLE_RATE_RST = 15'd512;

    // squared thresholds (level plus gravity, squared)
    localparam logic [SQ_W-1:0] HARD_FLICK_SQ_RST =
        SQ_W'((HARD_FLICK_RST + GRAVITY_Q8) * (HARD_FLICK_RST + GRAVITY_Q8));
    localparam logic [SQ_W-1:0] FLICK_SQ_RST =
        SQ_W'((FLICK_RST + GRAVITY_Q8) * (FLICK_RST + GRAVITY_Q8));
    localparam logic [SQ_W-1:0] SHAKE_SQ_RST =
        SQ_W'((SHAKE_RST + GRAVITY_Q8) * (SHAKE_RST + GRAVITY_Q8));
    localparam logic [SQ_W-1:0] STAB_SQ =
        SQ_W'((STAB_NET_Q8 + GRAVITY_Q8) * (STAB_NET_Q8 + GRAVITY_Q8));

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_HOLD_TIME   = 3'd0,
        REG_COOLDOWN    = 3'd1,
        REG_HARD_FLICK  = 3'd2,
        REG_FLICK       = 3'd3,
        REG_SHAKE       = 3'd4,
        REG_SWIPE_RATE  = 3'd5,
        REG_CIRCLE_RATE = 3'd6
    } t_reg_idx;

    // gesture codes
    typedef enum logic [3:0] {
        GEST_NONE        = 4'd0,
        GEST_FLICK       = 4'd1,
        GEST_HARD_FLICK  = 4'd2,
        GEST_SWIPE_LEFT  = 4'd3,
        GEST_SWIPE_RIGHT = 4'd4,
        GEST_SHAKE       = 4'd5,
        GEST_CIRCLE      = 4'd6,
        GEST_STAB        = 4'd7,
        GEST_HOLD        = 4'd8
    } t_gesture;

    // configuration as seen by the decision logic
    typedef struct packed {
        logic [CFG_W-1:0]   hold_time_ms;
        logic [CFG_W-1:0]   cooldown_ms;
        logic [SQ_W-1:0]    hard_flick_sq;
        logic [SQ_W-1:0]    flick_sq;
        logic [SQ_W-1:0]    shake_sq;
        logic [LEVEL_W-1:0] swipe_rate;
        logic [LEVEL_W-1:0] circle_rate_min;
    } t_cfg;

    // registered sample with squared accelerations
    typedef struct packed {
        logic                     valid;
        logic [TIME_W-1:0]        now;
        logic [SQ_W-1:0]          sq_x;
        logic [SQ_W-1:0]          sq_y;
        logic [SQ_W-1:0]          sq_z;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] gx;
        logic signed [AXIS_W-1:0] gz;
        logic                     button;
    } t_sample;

endpackage

`default_nettype wire

// ===== rtl/imu_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// imu_gesture_classifier
// Classifies one IMU sample per transaction into one gesture code.
//
// Input channel (i_in_valid / o_in_ready) carries a timestamp, three
// accelerations, x and z rates and the button bit. Output channel
// (o_out_valid / i_out_ready) carries one gesture code per sample.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_wdata);
// acceleration levels are squared at write time by one shared squarer.
// Path: a sample accepted into the input register (with axis squares)
// passes through the decision logic into the output register. Throughput:
// one sample per cycle while the receiver does not stall, set by the single
// pass through the decision logic, whose state feeds back on each advance.
// When the receiver stalls, the result holds in the output register, one
// more sample waits in the input register, then o_in_ready drops.
// Synchronous reset clears the pipeline, hold timer, cooldown time and
// yaw integral and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_gesture_classifier #(
    parameter int SAMPLE_RATE_HZ = imugc_pkg::SAMPLE_RATE_HZ_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [imugc_pkg::IDX_W-1:0]           i_cfg_idx,
    input  wire logic [imugc_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  wire logic                                  i_in_valid,
    output      logic                                  o_in_ready,
    input  wire logic [imugc_pkg::TIME_W-1:0]          i_timestamp_ms,
    input  wire logic signed [imugc_pkg::AXIS_W-1:0]   i_accel_x,
    input  wire logic signed [imugc_pkg::AXIS_W-1:0]   i_accel_y,
    input  wire logic signed [imugc_pkg::AXIS_W-1:0]   i_accel_z,
    input  wire logic signed [imugc_pkg::AXIS_W-1:0]   i_rate_x,
    input  wire logic signed [imugc_pkg::AXIS_W-1:0]   i_rate_z,
    input  wire logic                                  i_button_held,
    output      logic                                  o_out_valid,
    input  wire logic                                  i_out_ready,
    output      logic [3:0]                            o_gesture
);

    imugc_pkg::t_cfg     w_cfg;
    imugc_pkg::t_sample  w_smp;
    imugc_pkg::t_gesture w_code;
    logic                w_load;
    logic                w_adv;
    logic                r_out_valid;
    logic [3:0]          r_gesture;

    // handshake: the input stage moves on when the output register is free
    assign w_adv      = w_smp.valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !w_smp.valid || w_adv;
    assign w_load     = i_in_valid && o_in_ready;

    imugc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    imugc_sample u_sample (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_adv          (w_adv),
        .i_timestamp_ms (i_timestamp_ms),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_rate_x       (i_rate_x),
        .i_rate_z       (i_rate_z),
        .i_button_held  (i_button_held),
        .o_sample       (w_smp)
    );

    imugc_decide #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_sample (w_smp),
        .i_cfg    (w_cfg),
        .o_code   (w_code)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_gesture <= w_code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gesture   = r_gesture;

    // a stalled result never gets overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_adv)
        else $error("result overwritten while stalled");

    // an accepted transaction occupies the input stage next cycle
    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> w_smp.valid)
        else $error("accepted transaction lost");

    // backpressure only when both stages are full and the output stalls
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_smp.valid && r_out_valid && !i_out_ready))
        else $error("input stalled without cause");

    // every transaction leaving the input stage produces a result
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("result missing after decision pass");

endmodule

`default_nettype wire

// ===== rtl/imugc_cfg.sv =====
// ----------------------------------------------------------------------------
// imugc_cfg
// Configuration registers. Acceleration levels are stored as the square of
// level plus gravity, computed by one shared squarer at write time.
// ----------------------------------------------------------------------------
`default_nettype none

module imugc_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [imugc_pkg::IDX_W-1:0]       i_cfg_idx,
    input  wire logic [imugc_pkg::CFG_W-1:0]       i_cfg_wdata,
    output imugc_pkg::t_cfg                        o_cfg
);

    imugc_pkg::t_cfg r_cfg;
    logic [imugc_pkg::CFG_W-1:0] w_lvl_g;
    logic [2*imugc_pkg::CFG_W-1:0] w_lvl_sq;

    // level plus gravity, squared
    assign w_lvl_g  = {1'b0, i_cfg_wdata[imugc_pkg::LEVEL_W-1:0]}
                    + imugc_pkg::CFG_W'(imugc_pkg::GRAVITY_Q8);
    assign w_lvl_sq = w_lvl_g * w_lvl_g;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_time_ms    <= imugc_pkg::HOLD_TIME_RST;
            r_cfg.cooldown_ms     <= imugc_pkg::COOLDOWN_RST;
            r_cfg.hard_flick_sq   <= imugc_pkg::HARD_FLICK_SQ_RST;
            r_cfg.flick_sq        <= imugc_pkg::FLICK_SQ_RST;
            r_cfg.shake_sq        <= imugc_pkg::SHAKE_SQ_RST;
            r_cfg.swipe_rate      <= imugc_pkg::SWIPE_RATE_RST;
            r_cfg.circle_rate_min <= imugc_pkg::CIRCLE_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (imugc_pkg::t_reg_idx'(i_cfg_idx))
                imugc_pkg::REG_HOLD_TIME: begin
                    r_cfg.hold_time_ms <= i_cfg_wdata;
                end
                imugc_pkg::REG_COOLDOWN: begin
                    r_cfg.cooldown_ms <= i_cfg_wdata;
                end
                imugc_pkg::REG_HARD_FLICK: begin
                    r_cfg.hard_flick_sq <= w_lvl_sq[imugc_pkg::SQ_W-1:0];
                end
                imugc_pkg::REG_FLICK: begin
                    r_cfg.flick_sq <= w_lvl_sq[imugc_pkg::SQ_W-1:0];
                end
                imugc_pkg::REG_SHAKE: begin
                    r_cfg.shake_sq <= w_lvl_sq[imugc_pkg::SQ_W-1:0];
                end
                imugc_pkg::REG_SWIPE_RATE: begin
                    r_cfg.swipe_rate <= i_cfg_wdata[imugc_pkg::LEVEL_W-1:0];
                end
                imugc_pkg::REG_CIRCLE_RATE: begin
                    r_cfg.circle_rate_min <= i_cfg_wdata[imugc_pkg::LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/imugc_sample.sv =====
// ----------------------------------------------------------------------------
// imugc_sample
// Input register stage: captures one sample transaction and squares the
// three acceleration axes on the way in.
// ----------------------------------------------------------------------------
`default_nettype none

module imugc_sample (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_load,
    input  wire logic                                  i_adv,
    input  wire logic [imugc_pkg::TIME_W-1:0]          i_timestamp_ms,
    input  wire logic signed [imugc_pkg::AXIS_W-1:0]   i_accel_x,
    input  wire logic signed [imugc_pkg::AXIS_W-1:0]   i_accel_y,
    input  wire logic signed [imugc_pkg::AXIS_W-1:0]   i_accel_z,
    input  wire logic signed [imugc_pkg::AXIS_W-1:0]   i_rate_x,
    input  wire logic signed [imugc_pkg::AXIS_W-1:0]   i_rate_z,
    input  wire logic                                  i_button_held,
    output imugc_pkg::t_sample                         o_sample
);

    imugc_pkg::t_sample r_smp;
    logic signed [2*imugc_pkg::AXIS_W-1:0] w_sq_x;
    logic signed [2*imugc_pkg::AXIS_W-1:0] w_sq_y;
    logic signed [2*imugc_pkg::AXIS_W-1:0] w_sq_z;

    // squares are at most 2^30 and fit the low bits
    assign w_sq_x = i_accel_x * i_accel_x;
    assign w_sq_y = i_accel_y * i_accel_y;
    assign w_sq_z = i_accel_z * i_accel_z;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp.valid <= 1'b0;
        end else if (i_load) begin
            r_smp.valid <= 1'b1;
        end else if (i_adv) begin
            r_smp.valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_smp.now    <= i_timestamp_ms;
            r_smp.sq_x   <= w_sq_x[imugc_pkg::SQ_W-1:0];
            r_smp.sq_y   <= w_sq_y[imugc_pkg::SQ_W-1:0];
            r_smp.sq_z   <= w_sq_z[imugc_pkg::SQ_W-1:0];
            r_smp.ay     <= i_accel_y;
            r_smp.gx     <= i_rate_x;
            r_smp.gz     <= i_rate_z;
            r_smp.button <= i_button_held;
        end
    end

    assign o_sample = r_smp;

endmodule

`default_nettype wire

// ===== rtl/imugc_decide.sv =====
// ----------------------------------------------------------------------------
// imugc_decide
// Hold timer, cooldown gate, yaw integrator and the prioritized gesture
// tests. State advances once per transaction leaving the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module imugc_decide #(
    parameter int SAMPLE_RATE_HZ = imugc_pkg::SAMPLE_RATE_HZ_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  imugc_pkg::t_sample             i_sample,
    input  imugc_pkg::t_cfg                i_cfg,
    output imugc_pkg::t_gesture            o_code
);

    localparam int YAW_LIMIT  = 12 * 256 * SAMPLE_RATE_HZ;
    localparam int YAW_CIRCLE = 6 * 256 * SAMPLE_RATE_HZ;
    localparam int YAW_W      = $clog2(YAW_LIMIT + 32769) + 1;
    localparam int TW         = imugc_pkg::TIME_W;
    localparam int RW         = imugc_pkg::AXIS_W + 1;

    logic [TW-1:0]           r_last;
    logic [TW-1:0]           r_hold_start;
    logic                    r_armed;
    logic signed [YAW_W-1:0] r_yaw;
    logic [TW-1:0]           n_last;
    logic [TW-1:0]           n_hold_start;
    logic                    n_armed;
    logic signed [YAW_W-1:0] n_yaw;

    logic [TW-1:0]                      w_dt_hold;
    logic [TW-1:0]                      w_dt_last;
    logic                               w_hold_fire;
    logic                               w_cooling;
    logic [imugc_pkg::SUMSQ_W-1:0]      w_sumsq;
    logic                               w_hard;
    logic                               w_flick;
    logic                               w_shake;
    logic                               w_stab;
    logic signed [RW-1:0]               w_gz;
    logic signed [RW-1:0]               w_gx;
    logic signed [RW-1:0]               w_swipe;
    logic [RW-1:0]                      w_agz;
    logic [RW-1:0]                      w_agx;
    logic                               w_left;
    logic                               w_right;
    logic                               w_circle;
    logic signed [YAW_W-1:0]            w_yaw_sum;
    logic [YAW_W-1:0]                   w_yaw_sum_mag;
    logic signed [YAW_W-1:0]            w_yaw_clip;
    logic [YAW_W-1:0]                   w_yaw_clip_mag;

    // time differences, modulo 2^32
    assign w_dt_hold = i_sample.now - r_hold_start;
    assign w_dt_last = i_sample.now - r_last;
    assign w_hold_fire = i_sample.button && r_armed
                      && (w_dt_hold >= TW'(i_cfg.hold_time_ms))
                      && (w_dt_last > TW'(i_cfg.cooldown_ms));
    assign w_cooling = w_dt_last < TW'(i_cfg.cooldown_ms);

    // magnitude tests on the squared sum
    assign w_sumsq = imugc_pkg::SUMSQ_W'(i_sample.sq_x)
                   + imugc_pkg::SUMSQ_W'(i_sample.sq_y)
                   + imugc_pkg::SUMSQ_W'(i_sample.sq_z);
    assign w_hard  = w_sumsq > imugc_pkg::SUMSQ_W'(i_cfg.hard_flick_sq);
    assign w_flick = w_sumsq > imugc_pkg::SUMSQ_W'(i_cfg.flick_sq);
    assign w_shake = (w_sumsq > imugc_pkg::SUMSQ_W'(i_cfg.shake_sq))
                  && (w_agx > RW'(imugc_pkg::SHAKE_RATE_X_Q8));
    assign w_stab  = (i_sample.ay < imugc_pkg::AXIS_W'(imugc_pkg::STAB_AY_Q8))
                  && (w_sumsq > imugc_pkg::SUMSQ_W'(imugc_pkg::STAB_SQ));

    // rate tests
    assign w_gz    = RW'(i_sample.gz);
    assign w_gx    = RW'(i_sample.gx);
    assign w_swipe = $signed({2'b00, i_cfg.swipe_rate});
    assign w_agz   = w_gz[RW-1] ? RW'(-w_gz) : RW'(w_gz);
    assign w_agx   = w_gx[RW-1] ? RW'(-w_gx) : RW'(w_gx);
    assign w_left  = w_gz > w_swipe;
    assign w_right = w_gz < -w_swipe;

    // yaw integrator with clip to zero past the angle limit
    assign w_yaw_sum      = r_yaw + YAW_W'(i_sample.gz);
    assign w_yaw_sum_mag  = w_yaw_sum[YAW_W-1] ? YAW_W'(-w_yaw_sum) : YAW_W'(w_yaw_sum);
    assign w_yaw_clip     = (w_yaw_sum_mag > YAW_W'(YAW_LIMIT)) ? '0 : w_yaw_sum;
    assign w_yaw_clip_mag = (w_yaw_sum_mag > YAW_W'(YAW_LIMIT)) ? '0 : w_yaw_sum_mag;
    assign w_circle = (w_yaw_clip_mag > YAW_W'(YAW_CIRCLE))
                   && (w_agz > {2'b00, i_cfg.circle_rate_min});

    // next state and gesture code
    always_comb begin
        n_last       = r_last;
        n_hold_start = r_hold_start;
        n_armed      = r_armed;
        n_yaw        = r_yaw;
        o_code       = imugc_pkg::GEST_NONE;

        if (i_sample.button) begin
            if (!r_armed) begin
                n_armed      = 1'b1;
                n_hold_start = i_sample.now;
            end
        end else begin
            n_armed = 1'b0;
        end

        priority if (w_hold_fire) begin
            n_last  = i_sample.now;
            n_armed = 1'b0;
            o_code  = imugc_pkg::GEST_HOLD;
        end else if (w_cooling) begin
            o_code = imugc_pkg::GEST_NONE;
        end else begin
            n_yaw = w_yaw_clip;
            priority if (w_hard) begin
                o_code = imugc_pkg::GEST_HARD_FLICK;
            end else if (w_flick) begin
                o_code = imugc_pkg::GEST_FLICK;
            end else if (w_shake) begin
                o_code = imugc_pkg::GEST_SHAKE;
            end else if (w_stab) begin
                o_code = imugc_pkg::GEST_STAB;
            end else if (w_left) begin
                o_code = imugc_pkg::GEST_SWIPE_LEFT;
            end else if (w_right) begin
                o_code = imugc_pkg::GEST_SWIPE_RIGHT;
            end else if (w_circle) begin
                n_yaw  = '0;
                o_code = imugc_pkg::GEST_CIRCLE;
            end else begin
                o_code = imugc_pkg::GEST_NONE;
            end
            if (o_code != imugc_pkg::GEST_NONE) begin
                n_last = i_sample.now;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last       <= '0;
            r_hold_start <= '0;
            r_armed      <= 1'b0;
            r_yaw        <= '0;
        end else if (i_adv) begin
            r_last       <= n_last;
            r_hold_start <= n_hold_start;
            r_armed      <= n_armed;
            r_yaw        <= n_yaw;
        end
    end

endmodule

`default_nettype wire

// ===== tb/imu_gesture_classifier_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_gesture_classifier_test
// Self-checking bench for the IMU gesture classifier. A directed table walks
// the field extremes, every gesture, the cooldown and hold rules, the
// timestamp wrap and the register corner cases. Then random phases follow,
// each with fresh register settings and motion-shaped samples: rest, flicks,
// shakes, stabs, spins, threshold edges and noise. An in-bench model of the
// classifier predicts each gesture code, which is checked in order against
// the output channel while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module imu_gesture_classifier_test;

    import imugc_pkg::*;

    localparam int RATE_HZ       = 100;
    localparam int YAW_LIMIT     = 12 * 256 * RATE_HZ;
    localparam int CIRCLE_ANGLE  = 6 * 256 * RATE_HZ;
    localparam int LATENCY_CYC   = 4;
    localparam int SETTLE_CYC    = 20;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 160;
    localparam int BACKLOG_CYC   = 200;
    localparam int PLAN_LEN      = 27;

    // register index with no register behind it
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [TIME_W-1:0]        ts_ms;
        logic signed [AXIS_W-1:0] acc_x;
        logic signed [AXIS_W-1:0] acc_y;
        logic signed [AXIS_W-1:0] acc_z;
        logic signed [AXIS_W-1:0] rot_x;
        logic signed [AXIS_W-1:0] rot_z;
        logic                     btn;
    } imu_sample_t;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_e;

    typedef struct packed {
        row_kind_e        kind;
        logic [IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0] reg_val;
        imu_sample_t      smp;
        logic             fixed;
        t_gesture         want;
    } plan_row_t;

    typedef struct packed {
        logic [CFG_W-1:0]   hold_ms;
        logic [CFG_W-1:0]   cool_ms;
        logic [LEVEL_W-1:0] hard_lvl;
        logic [LEVEL_W-1:0] flick_lvl;
        logic [LEVEL_W-1:0] shake_lvl;
        logic [LEVEL_W-1:0] swipe_lvl;
        logic [LEVEL_W-1:0] circle_lvl;
    } cfg_shadow_t;

    // directed plan: register writes and samples, expected code typed where obvious
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // reset settings: cooldown window after reset
        '{ROW_SAMPLE, '0, '0, '{32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
          1'b1, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd1000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0,
          1'b0}, 1'b1, GEST_HARD_FLICK},
        '{ROW_SAMPLE, '0, '0, '{32'd1100, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0,
          1'b0}, 1'b1, GEST_NONE},
        // exactly at the end of the cooldown window
        '{ROW_SAMPLE, '0, '0, '{32'd1300, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
          1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd1600, 16'sd7000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
          1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd1900, 16'sd0, 16'sd0, 16'sd5000, 16'sh8000, 16'sd0,
          1'b0}, 1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd2200, 16'sd0, -16'sd4500, 16'sd0, 16'sd0, 16'sd0, 1'b0},
          1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd2500, 16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sh7FFF,
          1'b0}, 1'b0, GEST_NONE},
        // swipe right against the negated rate
        '{ROW_SAMPLE, '0, '0, '{32'd2800, 16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sh8000,
          1'b0}, 1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd3100, 16'sd0, 16'sd0, 16'sd2511, 16'sd0, -16'sd1024,
          1'b0}, 1'b0, GEST_NONE},
        // unknown index, then extremes; wide swipe value keeps its low bits
        '{ROW_WRITE, REG_SPARE, 16'hFFFF, '0, 1'b0, GEST_NONE},
        '{ROW_WRITE, REG_COOLDOWN, 16'h0000, '0, 1'b0, GEST_NONE},
        '{ROW_WRITE, REG_HOLD_TIME, 16'h0000, '0, 1'b0, GEST_NONE},
        '{ROW_WRITE, REG_SWIPE_RATE, 16'hFFFF, '0, 1'b0, GEST_NONE},
        '{ROW_WRITE, REG_CIRCLE_RATE, 16'h0000, '0, 1'b0, GEST_NONE},
        // spin up the yaw sum until a circle
        '{ROW_SAMPLE, '0, '0, '{32'd3200, 16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sh7FFF,
          1'b0}, 1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd3201, 16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sh7FFF,
          1'b0}, 1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd3202, 16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sh7FFF,
          1'b0}, 1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd3203, 16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sh7FFF,
          1'b0}, 1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd3204, 16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sh7FFF,
          1'b0}, 1'b0, GEST_NONE},
        // press arms, next pressed sample holds
        '{ROW_SAMPLE, '0, '0, '{32'd4000, 16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sd0, 1'b1},
          1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'd4001, 16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sd0, 1'b1},
          1'b0, GEST_NONE},
        '{ROW_WRITE, REG_COOLDOWN, 16'hFFFF, '0, 1'b0, GEST_NONE},
        '{ROW_WRITE, REG_HOLD_TIME, 16'hFFFF, '0, 1'b0, GEST_NONE},
        // timestamp wrap: cooldown and hold timer across zero
        '{ROW_SAMPLE, '0, '0, '{32'hFFFF_FF00, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          1'b0}, 1'b0, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'h0000_0010, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          1'b1}, 1'b1, GEST_NONE},
        '{ROW_SAMPLE, '0, '0, '{32'h0001_0010, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          1'b1}, 1'b0, GEST_NONE}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [IDX_W-1:0]         i_cfg_idx;
    logic [CFG_W-1:0]         i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [TIME_W-1:0]        i_timestamp_ms;
    logic signed [AXIS_W-1:0] i_accel_x;
    logic signed [AXIS_W-1:0] i_accel_y;
    logic signed [AXIS_W-1:0] i_accel_z;
    logic signed [AXIS_W-1:0] i_rate_x;
    logic signed [AXIS_W-1:0] i_rate_z;
    logic                     i_button_held;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [3:0]               o_gesture;

    // classifier shadow state
    cfg_shadow_t       shadow;
    logic [TIME_W-1:0] last_report_ms;
    logic [TIME_W-1:0] press_start_ms;
    logic              press_armed;
    longint            yaw_sum;

    // random motion state
    logic [TIME_W-1:0] clock_ms;
    logic              btn_now;
    int                btn_run;
    int                spin_dir;

    t_gesture gesture_due [$];
    int       fail_count;
    logic     backlog_req;

    imu_gesture_classifier #(
        .SAMPLE_RATE_HZ (RATE_HZ)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_timestamp_ms (i_timestamp_ms),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_rate_x       (i_rate_x),
        .i_rate_z       (i_rate_z),
        .i_button_held  (i_button_held),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_gesture      (o_gesture)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // squared threshold for a net acceleration level above gravity
    function automatic longint level_sq(longint lvl);
        return (lvl + GRAVITY_Q8) * (lvl + GRAVITY_Q8);
    endfunction

    function automatic void reset_shadow();
        shadow.hold_ms    = HOLD_TIME_RST;
        shadow.cool_ms    = COOLDOWN_RST;
        shadow.hard_lvl   = LEVEL_W'(HARD_FLICK_RST);
        shadow.flick_lvl  = LEVEL_W'(FLICK_RST);
        shadow.shake_lvl  = LEVEL_W'(SHAKE_RST);
        shadow.swipe_lvl  = SWIPE_RATE_RST;
        shadow.circle_lvl = CIRCLE_RATE_RST;
        last_report_ms    = '0;
        press_start_ms    = '0;
        press_armed       = 1'b0;
        yaw_sum           = 0;
    endfunction

    // one classification step: updates the shadow state, returns the code
    function automatic t_gesture predict_gesture(imu_sample_t s);
        logic [TIME_W-1:0] since_press;
        logic [TIME_W-1:0] since_last;
        longint            sq;
        longint            rx;
        longint            rz;
        longint            ry;
        t_gesture          g;
        since_press = s.ts_ms - press_start_ms;
        since_last  = s.ts_ms - last_report_ms;
        g  = GEST_NONE;
        rx = $signed(s.rot_x);
        rz = $signed(s.rot_z);
        ry = $signed(s.acc_y);
        sq = longint'($signed(s.acc_x)) * $signed(s.acc_x)
           + ry * ry
           + longint'($signed(s.acc_z)) * $signed(s.acc_z);

        // hold timer
        if (s.btn) begin
            if (!press_armed) begin
                press_armed    = 1'b1;
                press_start_ms = s.ts_ms;
            end else if (since_press >= shadow.hold_ms && since_last > shadow.cool_ms) begin
                last_report_ms = s.ts_ms;
                press_armed    = 1'b0;
                return GEST_HOLD;
            end
        end else begin
            press_armed = 1'b0;
        end

        // cooldown gate leaves the yaw sum alone
        if (since_last < shadow.cool_ms)
            return GEST_NONE;

        yaw_sum += rz;
        if (yaw_sum > YAW_LIMIT || yaw_sum < -YAW_LIMIT)
            yaw_sum = 0;

        // priority chain
        if (sq > level_sq(shadow.hard_lvl))
            g = GEST_HARD_FLICK;
        else if (sq > level_sq(shadow.flick_lvl))
            g = GEST_FLICK;
        else if (sq > level_sq(shadow.shake_lvl) &&
                 (rx > SHAKE_RATE_X_Q8 || rx < -SHAKE_RATE_X_Q8))
            g = GEST_SHAKE;
        else if (ry < STAB_AY_Q8 && sq > level_sq(STAB_NET_Q8))
            g = GEST_STAB;
        else if (rz > longint'(shadow.swipe_lvl))
            g = GEST_SWIPE_LEFT;
        else if (rz < -longint'(shadow.swipe_lvl))
            g = GEST_SWIPE_RIGHT;
        else if ((yaw_sum > CIRCLE_ANGLE || yaw_sum < -CIRCLE_ANGLE) &&
                 (rz > longint'(shadow.circle_lvl) || -rz > longint'(shadow.circle_lvl))) begin
            yaw_sum = 0;
            g = GEST_CIRCLE;
        end

        if (g != GEST_NONE)
            last_report_ms = s.ts_ms;
        return g;
    endfunction

    function automatic logic signed [AXIS_W-1:0] sat16(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[AXIS_W-1:0];
    endfunction

    function automatic int spread(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg_value(int typical);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return CFG_W'($urandom_range(0, typical));
        endcase
    endfunction

    // next random sample: motion-shaped values on an advancing clock
    function automatic imu_sample_t next_motion();
        imu_sample_t s;
        int          step;
        int          sgn;
        int          axis;
        int          axis_v;
        bit          on_axis;
        sgn     = $urandom_range(0, 1) ? 1 : -1;
        axis    = $urandom_range(0, 2);
        axis_v  = 0;
        on_axis = 1'b0;

        // timestamp step: small, around the cooldown window, wider, or zero with an occasional random jump
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:         step = $urandom_range(0, 20);
            6, 7, 8, 9, 10, 11, 12:   step = int'(shadow.cool_ms) + spread(5);
            13, 14, 15, 16, 17, 18:   step = $urandom_range(0, 2 * shadow.cool_ms + 100);
            default:                  step = 0;
        endcase
        if (step < 0)
            step = 0;
        if (step == 0 && $urandom_range(0, 3) == 0)
            clock_ms += $urandom();
        else
            clock_ms += step;
        s.ts_ms = clock_ms;

        // button runs
        if (btn_run == 0) begin
            btn_now = ~btn_now;
            btn_run = btn_now ? $urandom_range(1, 15) : $urandom_range(1, 6);
        end
        btn_run--;
        s.btn = ($urandom_range(0, 19) == 0) ? ~btn_now : btn_now;

        // at rest by default
        s.acc_x = sat16(spread(200));
        s.acc_y = sat16(spread(200));
        s.acc_z = sat16(GRAVITY_Q8 + spread(200));
        s.rot_x = sat16(spread(800));
        s.rot_z = sat16(spread(300));

        case ($urandom_range(0, 9))
            0: begin
                s.acc_x = $urandom();
                s.acc_y = $urandom();
                s.acc_z = $urandom();
                s.rot_x = $urandom();
                s.rot_z = $urandom();
            end
            1: ;
            2: begin
                on_axis = 1'b1;
                axis_v  = sgn * int'($urandom_range(3000, 14000));
            end
            3: begin
                on_axis = 1'b1;
                axis_v  = sgn * int'($urandom_range(4000, 7500));
                s.rot_x = sat16(spread(5000));
            end
            4: s.acc_y = sat16(-int'($urandom_range(1500, 7000)));
            5, 6: s.rot_z = sat16(spin_dir * int'($urandom_range(200, 3000)));
            7: s.rot_z = sat16(sgn * (int'(shadow.swipe_lvl) + spread(1)));
            8: begin
                on_axis = 1'b1;
                case ($urandom_range(0, 3))
                    0:       axis_v = int'(shadow.hard_lvl);
                    1:       axis_v = int'(shadow.flick_lvl);
                    2:       axis_v = int'(shadow.shake_lvl);
                    default: axis_v = STAB_NET_Q8;
                endcase
                axis_v  = sgn * (axis_v + GRAVITY_Q8 + spread(1));
                s.rot_x = sat16(sgn * (SHAKE_RATE_X_Q8 + spread(1)));
                s.rot_z = sat16(sgn * (int'(shadow.circle_lvl) + spread(1)));
            end
            default: begin
                s.acc_x = sat16(spread(3000));
                s.acc_y = sat16(spread(3000));
                s.acc_z = sat16(spread(3000));
                s.rot_x = sat16(spread(3000));
                s.rot_z = sat16(spread(3000));
            end
        endcase

        // a single dominant axis, the others quiet
        if (on_axis) begin
            s.acc_x = '0;
            s.acc_y = '0;
            s.acc_z = '0;
            case (axis)
                0:       s.acc_x = sat16(axis_v);
                1:       s.acc_y = sat16(axis_v);
                default: s.acc_z = sat16(axis_v);
            endcase
        end
        return s;
    endfunction

    // offer one sample until accepted, then queue its expected gesture
    task automatic send_sample(imu_sample_t s, logic fixed, t_gesture want);
        t_gesture g;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_timestamp_ms <= s.ts_ms;
        i_accel_x      <= s.acc_x;
        i_accel_y      <= s.acc_y;
        i_accel_z      <= s.acc_z;
        i_rate_x       <= s.rot_x;
        i_rate_z       <= s.rot_z;
        i_button_held  <= s.btn;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        g = predict_gesture(s);
        gesture_due.push_back(fixed ? want : g);
    endtask

    task automatic idle_in(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // wait until every expected gesture has come out, then let the pipe settle
    task automatic go_quiet();
        int waited;
        waited = 0;
        idle_in(1);
        while (gesture_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (gesture_due.size() != 0) begin
            $error("gesture: %0d expected transactions never arrived", gesture_due.size());
            fail_count++;
        end
        repeat (LATENCY_CYC) @(negedge i_clk);
    endtask

    // register write; the level squarer gets time before anything else
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        repeat (SETTLE_CYC) @(negedge i_clk);
        case (idx)
            REG_HOLD_TIME:   shadow.hold_ms    = val;
            REG_COOLDOWN:    shadow.cool_ms    = val;
            REG_HARD_FLICK:  shadow.hard_lvl   = val[LEVEL_W-1:0];
            REG_FLICK:       shadow.flick_lvl  = val[LEVEL_W-1:0];
            REG_SHAKE:       shadow.shake_lvl  = val[LEVEL_W-1:0];
            REG_SWIPE_RATE:  shadow.swipe_lvl  = val[LEVEL_W-1:0];
            REG_CIRCLE_RATE: shadow.circle_lvl = val[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    // stimulus
    initial begin : stimulus
        int burst;
        logic lvl_hi;
        logic lvl_lo;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_timestamp_ms = '0;
        i_accel_x      = '0;
        i_accel_y      = '0;
        i_accel_z      = '0;
        i_rate_x       = '0;
        i_rate_z       = '0;
        i_button_held  = 1'b0;
        backlog_req    = 1'b0;
        fail_count     = 0;
        btn_now        = 1'b0;
        btn_run        = 0;
        spin_dir       = 1;
        reset_shadow();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed plan
        for (int r = 0; r < PLAN_LEN; r++) begin
            if (PLAN[r].kind == ROW_WRITE) begin
                go_quiet();
                write_reg(PLAN[r].reg_idx, PLAN[r].reg_val);
            end else begin
                send_sample(PLAN[r].smp, PLAN[r].fixed, PLAN[r].want);
                idle_in($urandom_range(0, 2));
            end
        end
        clock_ms = PLAN[PLAN_LEN-1].smp.ts_ms;

        // random phases, each with its own register settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            go_quiet();
            lvl_hi = (ph == 0);
            lvl_lo = (ph == 1);
            write_reg(REG_HOLD_TIME, pick_reg_value(2000));
            write_reg(REG_COOLDOWN, pick_reg_value(500));
            write_reg(REG_HARD_FLICK, lvl_hi ? 16'h7FFF : lvl_lo ? 16'h0 : pick_reg_value(9000));
            write_reg(REG_FLICK, lvl_hi ? 16'h7FFF : lvl_lo ? 16'h0 : pick_reg_value(7000));
            write_reg(REG_SHAKE, lvl_hi ? 16'h7FFF : lvl_lo ? 16'h0 : pick_reg_value(5000));
            write_reg(REG_SWIPE_RATE, lvl_hi ? 16'h7FFF : lvl_lo ? 16'h0 : pick_reg_value(4000));
            write_reg(REG_CIRCLE_RATE, lvl_hi ? 16'h7FFF : lvl_lo ? 16'h0 : pick_reg_value(2000));
            if ($urandom_range(0, 1))
                write_reg(REG_SPARE, 16'($urandom()));

            burst = $urandom_range(1, 40);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 10)
                    backlog_req = 1'b1;
                send_sample(next_motion(), 1'b0, GEST_NONE);
                burst--;
                if (burst == 0) begin
                    idle_in($urandom_range(1, 12));
                    burst    = $urandom_range(1, 60);
                    spin_dir = $urandom_range(0, 1) ? 1 : -1;
                end
            end
        end

        go_quiet();
        repeat (LATENCY_CYC * 4) @(negedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // result side: stall patterns, plus one long hold-off on request
    initial begin : result_side
        int mode;
        int mode_left;
        int hold_left;
        logic [15:0] ring;
        mode        = 0;
        mode_left   = 50;
        hold_left   = 0;
        ring        = 16'hA5C3;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (backlog_req) begin
                hold_left   = BACKLOG_CYC;
                backlog_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
                ring      = 16'($urandom());
            end
            mode_left--;
            ring = {ring[14:0], ring[15]};
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ring[0];
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_gesture due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (gesture_due.size() == 0) begin
                $error("gesture: unexpected transaction, got %0d", o_gesture);
                fail_count++;
            end else begin
                due = gesture_due.pop_front();
                if (o_gesture !== due) begin
                    $error("gesture: expected %0d, got %0d", due, o_gesture);
                    fail_count++;
                end
            end
        end
    end

    // run limit, far beyond the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/imugc_pkg.sv
rtl/imugc_cfg.sv
rtl/imugc_sample.sv
rtl/imugc_decide.sv
rtl/imu_gesture_classifier.sv
tb/imu_gesture_classifier_test.sv
